@@ hw/rtl/soa_pkg.sv @@
// Shared types, constants and helpers for the slab object allocator.
`timescale 1ns / 1ps
package soa_pkg;

  localparam int DEF_PAGES = 64;
  localparam int NCLS = 6;
  localparam int HDR_BYTES = 28;
  // Region is 4 MiB aligned, so its upper ten address bits identify it
  localparam logic [9:0] REGION_HI = 10'h350;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BIG  = 2'd1;
  localparam logic [1:0] ST_NOPG = 2'd2;
  localparam logic [1:0] ST_IGN  = 2'd3;

  // Per-page header record
  typedef struct packed {
    logic       live;
    logic [2:0] cls;
    logic       full;
    logic [7:0] cnt;
    logic [7:0] fresh;
    logic [8:0] dep;
  } soa_page_t;

  // Control of the shared offset unit
  typedef struct packed {
    logic       dec;
    logic [2:0] cls;
  } soa_ou_ctl_t;

  // Size to class; NCLS means too large
  function automatic logic [2:0] size_class(input logic [11:0] sz);
    logic [2:0] c;
    if (sz <= 12'd16) c = 3'd0;
    else if (sz <= 12'd32) c = 3'd1;
    else if (sz <= 12'd64) c = 3'd2;
    else if (sz <= 12'd128) c = 3'd3;
    else if (sz <= 12'd256) c = 3'd4;
    else if (sz <= 12'd512) c = 3'd5;
    else c = 3'(NCLS);
    return c;
  endfunction

  // Objects per page: (4096 - 28) / class bytes
  function automatic logic [7:0] objs_per_page(input logic [2:0] c);
    logic [7:0] n;
    case (c)
      3'd0: n = 8'd254;
      3'd1: n = 8'd127;
      3'd2: n = 8'd63;
      3'd3: n = 8'd31;
      3'd4: n = 8'd15;
      default: n = 8'd7;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] cls_mod(input logic [2:0] c);
    return (c >= 3'(NCLS)) ? c - 3'(NCLS) : c;
  endfunction

endpackage

@@ hw/rtl/soa_ram.sv @@
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module soa_ram #(
  parameter int W = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                           rdata
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ hw/rtl/soa_off_unit.sv @@
// Shared in-page offset unit: object offset on allocate, slot decode on free.
`timescale 1ns / 1ps
module soa_off_unit
  import soa_pkg::*;
(
  input  soa_ou_ctl_t ctl,
  input  logic [7:0]  idx,
  input  logic [11:0] rel,
  output logic [11:0] off,
  output logic [11:0] oidx,
  output logic        aligned
);
  logic [3:0]  sh;
  logic [11:0] opa;
  logic [11:0] opb;
  logic [11:0] sum;
  logic [11:0] mask;

  // Class bytes are 16 << cls
  assign sh = 4'(ctl.cls) + 4'd4;

  // One adder: header + (idx << sh), or rel - header
  assign opa = ctl.dec ? rel : (12'(idx) << sh);
  assign opb = ctl.dec ? (12'd0 - 12'(HDR_BYTES)) : 12'(HDR_BYTES);
  assign sum = opa + opb;

  assign mask    = (12'd1 << sh) - 12'd1;
  assign off     = sum;
  assign oidx    = sum >> sh;
  assign aligned = ((sum & mask) == 12'd0);
endmodule

@@ hw/rtl/slab_object_allocator_core.sv @@
// Slab object allocator: request sequencer, page tables and list memories.
`timescale 1ns / 1ps
// One request (allocate or free) is taken when start is high and busy is low.
// A refused or out-of-region request is answered straight from the decode
// state; an allocation that pops its page's freed-slot stack and fills its
// page runs through the decode, read, stack, update, unlink and address states
// first. The sequencer walks the page table, freed-slot stack and partial-list
// memories through registered reads, and one shared offset unit forms the
// object address or decodes the freed address. out_valid is high for exactly
// one cycle per request and the result cannot be held off. busy is low in that
// cycle, so the next request may be presented alongside it, and each request
// holds the block until its result strobe. No clearing pass runs after reset:
// page liveness is qualified by the bump pointer.
module slab_object_allocator_core
  import soa_pkg::*;
#(
  parameter int PAGES = DEF_PAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [11:0] in_size,
  input  logic [31:0] in_address,
  input  logic        in_page_available,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_object_address,
  output logic        out_page_obtained,
  output logic        out_page_released,
  output logic [31:0] out_page_address,
  output logic [6:0]  out_total_pages
);
  localparam int PW  = $clog2(PAGES + 1);
  localparam int PIW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int FSD = PAGES * 256;
  localparam int FAW = $clog2(FSD);
  localparam logic [PW-1:0] NIL = PW'(PAGES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_VPOP  = 4'd2;
  localparam logic [3:0] S_NEWPG = 4'd3;
  localparam logic [3:0] S_AREAD = 4'd4;
  localparam logic [3:0] S_FSTK  = 4'd5;
  localparam logic [3:0] S_AUPD  = 4'd6;
  localparam logic [3:0] S_CLR   = 4'd7;
  localparam logic [3:0] S_ADDR  = 4'd8;
  localparam logic [3:0] S_FREAD = 4'd9;
  localparam logic [3:0] S_FUPD  = 4'd10;
  localparam logic [3:0] S_FPUSH = 4'd11;

  // Control state
  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] head_r [NCLS];
  logic [PW-1:0] head_nxt [NCLS];
  logic [PW-1:0] held_r, held_nxt;
  logic [PW-1:0] bump_r, bump_nxt;
  logic [PW-1:0] vfd_r, vfd_nxt;
  logic          ov_r, ov_nxt;

  // Request and working registers
  logic          op_r, op_nxt;
  logic [11:0]   size_r, size_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic          avail_r, avail_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [2:0]    c_r, c_nxt;
  soa_page_t     pg_r, pg_nxt;
  logic [PW-1:0] nx_r, nx_nxt;
  logic [PW-1:0] pv_r, pv_nxt;
  logic [7:0]    idx_r, idx_nxt;

  // Result registers
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   obj_r, obj_nxt;
  logic          got_r, got_nxt;
  logic          rel_r, rel_nxt;
  logic [31:0]   paddr_r, paddr_nxt;

  // Memory ports
  logic           pg_we;
  logic [PIW-1:0] pg_wa, pg_ra;
  soa_page_t      pg_wd, pg_rd;
  logic           nx_we;
  logic [PIW-1:0] nx_wa, nx_ra;
  logic [PW-1:0]  nx_wd, nx_rd;
  logic           pv_we;
  logic [PIW-1:0] pv_wa, pv_ra;
  logic [PW-1:0]  pv_wd, pv_rd;
  logic           fs_we;
  logic [FAW-1:0] fs_wa, fs_ra;
  logic [7:0]     fs_wd, fs_rd;
  logic           vs_we;
  logic [PIW-1:0] vs_wa, vs_ra;
  logic [PW-1:0]  vs_wd, vs_rd;

  // Shared offset unit
  soa_ou_ctl_t ou_ctl;
  logic [7:0]  ou_idx;
  logic [11:0] ou_off;
  logic [11:0] ou_oidx;
  logic        ou_aligned;

  // Decode helpers
  logic [2:0]  dec_cls;
  logic [2:0]  hsel;
  logic [9:0]  fpage;
  logic [2:0]  fcls;
  logic [7:0]  n_cur;
  logic        flive;
  logic [7:0]  cnt_new;
  logic [8:0]  dep_m1;
  logic [7:0]  fresh_m1;

  soa_ram #(.W($bits(soa_page_t)), .DEPTH(PAGES)) u_pg_ram (
    .clk(clk), .we(pg_we), .waddr(pg_wa), .wdata(pg_wd), .raddr(pg_ra), .rdata(pg_rd)
  );
  soa_ram #(.W(PW), .DEPTH(PAGES)) u_nx_ram (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
  );
  soa_ram #(.W(PW), .DEPTH(PAGES)) u_pv_ram (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
  );
  soa_ram #(.W(8), .DEPTH(FSD)) u_fs_ram (
    .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd)
  );
  soa_ram #(.W(PW), .DEPTH(PAGES)) u_vs_ram (
    .clk(clk), .we(vs_we), .waddr(vs_wa), .wdata(vs_wd), .raddr(vs_ra), .rdata(vs_rd)
  );

  soa_off_unit u_off (
    .ctl(ou_ctl), .idx(ou_idx), .rel(addr_r[11:0]),
    .off(ou_off), .oidx(ou_oidx), .aligned(ou_aligned)
  );

  assign busy = (state_r != S_IDLE);

  // Combinational decode shared by the sequencer
  assign dec_cls  = size_class(size_r);
  assign hsel     = (dec_cls < 3'(NCLS)) ? dec_cls : 3'd0;
  assign fpage    = addr_r[21:12];
  assign fcls     = cls_mod(pg_rd.cls);
  assign n_cur    = objs_per_page(c_r);
  assign flive    = (p_r < bump_r) && pg_rd.live;
  assign dep_m1   = pg_rd.dep - 9'd1;
  assign fresh_m1 = pg_rd.fresh - 8'd1;
  assign cnt_new  = (state_r == S_FUPD) ? pg_r.cnt + 8'd1 :
                    ((pg_r.cnt != 8'd0) ? pg_r.cnt - 8'd1 : 8'd0);

  assign ou_ctl.dec = (state_r == S_FREAD);
  assign ou_ctl.cls = (state_r == S_FREAD) ? fcls : c_r;
  assign ou_idx     = idx_r;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    for (int i = 0; i < NCLS; i++) begin
      head_nxt[i] = head_r[i];
    end
    held_nxt   = held_r;
    bump_nxt   = bump_r;
    vfd_nxt    = vfd_r;
    ov_nxt     = 1'b0;
    op_nxt     = op_r;
    size_nxt   = size_r;
    addr_nxt   = addr_r;
    avail_nxt  = avail_r;
    p_nxt      = p_r;
    c_nxt      = c_r;
    pg_nxt     = pg_r;
    nx_nxt     = nx_r;
    pv_nxt     = pv_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    obj_nxt    = obj_r;
    got_nxt    = got_r;
    rel_nxt    = rel_r;
    paddr_nxt  = paddr_r;

    pg_we = 1'b0;
    pg_wa = p_r[PIW-1:0];
    pg_wd = pg_r;
    pg_ra = p_r[PIW-1:0];
    nx_we = 1'b0;
    nx_wa = p_r[PIW-1:0];
    nx_wd = NIL;
    nx_ra = p_r[PIW-1:0];
    pv_we = 1'b0;
    pv_wa = p_r[PIW-1:0];
    pv_wd = NIL;
    pv_ra = p_r[PIW-1:0];
    fs_we = 1'b0;
    fs_wa = FAW'({p_r[PIW-1:0], pg_r.dep[7:0]});
    fs_wd = idx_r;
    fs_ra = FAW'({p_r[PIW-1:0], dep_m1[7:0]});
    vs_we = 1'b0;
    vs_wa = vfd_r[PIW-1:0];
    vs_wd = p_r;
    vs_ra = vfd_nxt[PIW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_operation;
          size_nxt   = in_size;
          addr_nxt   = in_address;
          avail_nxt  = in_page_available;
          status_nxt = ST_OK;
          obj_nxt    = 32'd0;
          got_nxt    = 1'b0;
          rel_nxt    = 1'b0;
          paddr_nxt  = 32'd0;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        if (!op_r) begin
          c_nxt = dec_cls;
          pg_ra = head_r[hsel][PIW-1:0];
          nx_ra = head_r[hsel][PIW-1:0];
          pv_ra = head_r[hsel][PIW-1:0];
          if (dec_cls == 3'(NCLS)) begin
            status_nxt = ST_BIG;
            ov_nxt     = 1'b1;
            state_nxt  = S_IDLE;
          end else if (head_r[hsel] < NIL) begin
            p_nxt     = head_r[hsel];
            state_nxt = S_AREAD;
          end else if (avail_r && vfd_r != '0) begin
            vfd_nxt   = vfd_r - 1'b1;
            vs_ra     = vfd_nxt[PIW-1:0];
            state_nxt = S_VPOP;
          end else if (avail_r && bump_r < NIL) begin
            p_nxt     = bump_r;
            bump_nxt  = bump_r + 1'b1;
            state_nxt = S_NEWPG;
          end else begin
            status_nxt = ST_NOPG;
            ov_nxt     = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          pg_ra = PIW'(fpage);
          nx_ra = PIW'(fpage);
          pv_ra = PIW'(fpage);
          if (addr_r[31:22] == REGION_HI && {1'b0, fpage} < 11'(PAGES)) begin
            p_nxt     = PW'(fpage);
            state_nxt = S_FREAD;
          end else begin
            status_nxt = ST_IGN;
            ov_nxt     = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_VPOP: begin
        p_nxt     = vs_rd;
        state_nxt = S_NEWPG;
      end
      // Map a new page and hand out its highest object
      S_NEWPG: begin
        pg_we       = 1'b1;
        pg_wd.live  = 1'b1;
        pg_wd.cls   = c_r;
        pg_wd.full  = 1'b0;
        pg_wd.cnt   = n_cur - 8'd1;
        pg_wd.fresh = n_cur - 8'd1;
        pg_wd.dep   = 9'd0;
        nx_we       = 1'b1;
        pv_we       = 1'b1;
        head_nxt[c_r] = p_r;
        held_nxt    = held_r + 1'b1;
        got_nxt     = 1'b1;
        paddr_nxt   = {REGION_HI, 10'(p_r), 12'h000};
        idx_nxt     = n_cur - 8'd1;
        state_nxt   = S_ADDR;
      end
      // Pick a slot: freed stack first, then the fresh mark
      S_AREAD: begin
        pg_nxt = pg_rd;
        nx_nxt = nx_rd;
        pv_nxt = pv_rd;
        if (pg_rd.dep != 9'd0) begin
          pg_nxt.dep = dep_m1;
          state_nxt  = S_FSTK;
        end else if (pg_rd.fresh != 8'd0) begin
          pg_nxt.fresh = fresh_m1;
          idx_nxt      = fresh_m1;
          state_nxt    = S_AUPD;
        end else begin
          idx_nxt   = 8'd0;
          state_nxt = S_AUPD;
        end
      end
      S_FSTK: begin
        idx_nxt   = fs_rd;
        state_nxt = S_AUPD;
      end
      // Count down; a page with nothing left leaves the partial list
      S_AUPD: begin
        pg_we     = 1'b1;
        pg_wd.cnt = cnt_new;
        if (cnt_new == 8'd0) begin
          pg_wd.full = 1'b1;
          if (pv_r < NIL) begin
            nx_we = 1'b1;
            nx_wa = pv_r[PIW-1:0];
            nx_wd = nx_r;
          end else begin
            head_nxt[c_r] = nx_r;
          end
          if (nx_r < NIL) begin
            pv_we = 1'b1;
            pv_wa = nx_r[PIW-1:0];
            pv_wd = pv_r;
          end
          state_nxt = S_CLR;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      // Detach the unlinked page's own links
      S_CLR: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        if (op_r) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        obj_nxt   = {REGION_HI, 10'(p_r), ou_off};
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      // Validate the freed address against the page header
      S_FREAD: begin
        if (flive && addr_r[11:0] >= 12'(HDR_BYTES) && ou_aligned &&
            ou_oidx < 12'(objs_per_page(fcls))) begin
          c_nxt     = fcls;
          idx_nxt   = ou_oidx[7:0];
          pg_nxt    = pg_rd;
          nx_nxt    = nx_rd;
          pv_nxt    = pv_rd;
          state_nxt = S_FUPD;
        end else begin
          status_nxt = ST_IGN;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FUPD: begin
        status_nxt = ST_OK;
        pg_we      = 1'b1;
        pg_wd.cnt  = cnt_new;
        if (pg_r.dep < 9'd256) begin
          fs_we     = 1'b1;
          pg_wd.dep = pg_r.dep + 9'd1;
        end
        if (pg_r.full) begin
          // Full page rejoins the head of its partial list
          pg_wd.full    = 1'b0;
          nx_we         = 1'b1;
          nx_wd         = head_r[c_r];
          pv_we         = 1'b1;
          head_nxt[c_r] = p_r;
          nx_nxt        = head_r[c_r];
          if (head_r[c_r] < NIL) begin
            state_nxt = S_FPUSH;
          end else begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (cnt_new >= n_cur) begin
          // Every object free: release the page
          pg_wd.live = 1'b0;
          if (pv_r < NIL) begin
            nx_we = 1'b1;
            nx_wa = pv_r[PIW-1:0];
            nx_wd = nx_r;
          end else begin
            head_nxt[c_r] = nx_r;
          end
          if (nx_r < NIL) begin
            pv_we = 1'b1;
            pv_wa = nx_r[PIW-1:0];
            pv_wd = pv_r;
          end
          if (vfd_r < NIL) begin
            vs_we   = 1'b1;
            vfd_nxt = vfd_r + 1'b1;
          end
          if (held_r != '0) begin
            held_nxt = held_r - 1'b1;
          end
          rel_nxt   = 1'b1;
          paddr_nxt = {REGION_HI, 10'(p_r), 12'h000};
          state_nxt = S_CLR;
        end else begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FPUSH: begin
        pv_we     = 1'b1;
        pv_wa     = nx_r[PIW-1:0];
        pv_wd     = p_r;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < NCLS; i++) begin
        head_r[i] <= NIL;
      end
      held_r <= '0;
      bump_r <= '0;
      vfd_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      for (int i = 0; i < NCLS; i++) begin
        head_r[i] <= head_nxt[i];
      end
      held_r <= held_nxt;
      bump_r <= bump_nxt;
      vfd_r  <= vfd_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    size_r   <= size_nxt;
    addr_r   <= addr_nxt;
    avail_r  <= avail_nxt;
    p_r      <= p_nxt;
    c_r      <= c_nxt;
    pg_r     <= pg_nxt;
    nx_r     <= nx_nxt;
    pv_r     <= pv_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    obj_r    <= obj_nxt;
    got_r    <= got_nxt;
    rel_r    <= rel_nxt;
    paddr_r  <= paddr_nxt;
  end

  assign out_valid          = ov_r;
  assign out_status         = status_r;
  assign out_object_address = obj_r;
  assign out_page_obtained  = got_r;
  assign out_page_released  = rel_r;
  assign out_page_address   = paddr_r;
  assign out_total_pages    = 7'(held_r);

  // Result strobe lasts one cycle and only once the sequencer is back idle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r) else $error("result strobe longer than one cycle");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !busy) else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not start");
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= bump_r) else $error("held pages exceed mapped slots");
  a_vstk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vfd_r <= bump_r) else $error("released slot stack deeper than bump");
endmodule

@@ tb/slab_alloc_checker.sv @@
// Checker for the slab object allocator: predicts each result and compares it.
`timescale 1ns / 1ps
module slab_alloc_checker
  import soa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_operation,
  input  logic [11:0] in_size,
  input  logic [31:0] in_address,
  input  logic        in_page_available,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_object_address,
  input  logic        out_page_obtained,
  input  logic        out_page_released,
  input  logic [31:0] out_page_address,
  input  logic [6:0]  out_total_pages,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          alloc_ok_count,
  output int          release_count,
  output int          nopage_count
);

  localparam int NPG = 64;
  localparam int NIL = NPG;
  localparam logic [31:0] BASE = 32'hD4000000;
  localparam logic [31:0] REGION = 32'h00400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] obj;
    logic        got;
    logic        rel;
    logic [31:0] paddr;
    logic [6:0]  total;
  } alloc_result_t;

  alloc_result_t expected_results[$];

  // Predictor copy of the allocator state
  bit       pg_live[NPG];
  int       pg_cls[NPG];
  bit       pg_full[NPG];
  int       pg_cnt[NPG];
  int       pg_fresh[NPG];
  int       pg_dep[NPG];
  int       pg_stack[NPG][256];
  int       pl_next[NPG];
  int       pl_prev[NPG];
  int       pl_head[NCLS];
  int       held;
  int       bump;
  int       slot_stack[NPG];
  int       slot_depth;

  function automatic int cls_bytes(int c);
    return 16 << c;
  endfunction

  function automatic void list_push(int c, int p);
    int h;
    h = pl_head[c];
    pl_prev[p] = NIL;
    pl_next[p] = h;
    if (h < NPG) pl_prev[h] = p;
    pl_head[c] = p;
  endfunction

  function automatic void list_unlink(int c, int p);
    int pv;
    int nx;
    pv = pl_prev[p];
    nx = pl_next[p];
    if (pv < NPG) pl_next[pv] = nx;
    else pl_head[c] = nx;
    if (nx < NPG) pl_prev[nx] = pv;
    pl_prev[p] = NIL;
    pl_next[p] = NIL;
  endfunction

  // Works out the result of one request and updates the predictor state
  function automatic alloc_result_t serve_request(bit op, int sz, logic [31:0] addr, bit avail);
    alloc_result_t r;
    int c;
    int p;
    int idx;
    int n;
    int off;
    int rel_off;
    r = '0;
    if (!op) begin
      c = NCLS;
      for (int i = 0; i < NCLS; i++) begin
        if (sz <= cls_bytes(i)) begin
          c = i;
          break;
        end
      end
      if (c >= NCLS) begin
        r.status = ST_BIG;
      end else begin
        p = pl_head[c];
        if (p >= NPG) begin
          p = NIL;
          if (avail) begin
            if (slot_depth > 0) begin
              slot_depth--;
              p = slot_stack[slot_depth];
            end else if (bump < NPG) begin
              p = bump;
              bump++;
            end
          end
          if (p < NPG) begin
            n = 4068 / cls_bytes(c);
            pg_live[p] = 1;
            pg_cls[p] = c;
            pg_full[p] = 0;
            pg_cnt[p] = n;
            pg_fresh[p] = n;
            pg_dep[p] = 0;
            list_push(c, p);
            held++;
            r.got = 1;
            r.paddr = BASE + p * 4096;
          end
        end
        if (p >= NPG) begin
          r.status = ST_NOPG;
        end else begin
          if (pg_dep[p] > 0) begin
            pg_dep[p]--;
            idx = pg_stack[p][pg_dep[p]];
          end else if (pg_fresh[p] > 0) begin
            pg_fresh[p]--;
            idx = pg_fresh[p];
          end else begin
            idx = 0;
          end
          r.obj = BASE + p * 4096 + HDR_BYTES + idx * cls_bytes(c);
          if (pg_cnt[p] > 0) pg_cnt[p]--;
          if (pg_cnt[p] == 0) begin
            list_unlink(c, p);
            pg_full[p] = 1;
          end
        end
      end
    end else begin
      r.status = ST_IGN;
      if (addr != 0 && addr >= BASE && addr - BASE < REGION) begin
        off = addr - BASE;
        p = off / 4096;
        rel_off = off % 4096;
        if (p < NPG && pg_live[p] && rel_off >= HDR_BYTES) begin
          c = pg_cls[p];
          n = 4068 / cls_bytes(c);
          idx = (rel_off - HDR_BYTES) / cls_bytes(c);
          if ((rel_off - HDR_BYTES) % cls_bytes(c) == 0 && idx < n) begin
            r.status = ST_OK;
            if (pg_dep[p] < 256) begin
              pg_stack[p][pg_dep[p]] = idx;
              pg_dep[p]++;
            end
            pg_cnt[p]++;
            if (pg_full[p]) begin
              pg_full[p] = 0;
              list_push(c, p);
            end else if (pg_cnt[p] >= n) begin
              list_unlink(c, p);
              pg_live[p] = 0;
              if (slot_depth < NPG) begin
                slot_stack[slot_depth] = p;
                slot_depth++;
              end
              if (held > 0) held--;
              r.rel = 1;
              r.paddr = BASE + p * 4096;
            end
          end
        end
      end
    end
    r.total = 7'(held);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
    $display("%0t: mismatch on %s: got %h expected %h", $realtime, what, got_v, exp_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    alloc_ok_count = 0;
    release_count = 0;
    nopage_count = 0;
    held = 0;
    bump = 0;
    slot_depth = 0;
    for (int i = 0; i < NCLS; i++) pl_head[i] = NIL;
    for (int i = 0; i < NPG; i++) begin
      pg_live[i] = 0;
      pg_cls[i] = 0;
    end
  end

  assign pending_count = expected_results.size();

  // Predict on each accepted request, compare on each result strobe
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n) begin
      if (out_valid) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_status != e.status) report_mismatch("status", out_status, e.status);
          if (out_object_address != e.obj) report_mismatch("object_address", out_object_address, e.obj);
          if (out_page_obtained != e.got) report_mismatch("page_obtained", out_page_obtained, e.got);
          if (out_page_released != e.rel) report_mismatch("page_released", out_page_released, e.rel);
          if (out_page_address != e.paddr) report_mismatch("page_address", out_page_address, e.paddr);
          if (out_total_pages != e.total) report_mismatch("total_pages", out_total_pages, e.total);
          if (e.obj != 0) alloc_ok_count++;
          if (e.rel) release_count++;
          if (e.status == ST_NOPG) nopage_count++;
        end
      end
      if (start && !busy)
        expected_results.push_back(serve_request(in_operation, in_size, in_address,
                                                 in_page_available));
    end
  end

endmodule

@@ tb/tb_slab_object_allocator_core.sv @@
// Testbench top for the slab object allocator: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb_slab_object_allocator_core
  import soa_pkg::*;
();

  localparam logic [31:0] BASE = 32'hD4000000;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;
  localparam int LIMIT_CYCLES = 400000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [11:0] in_size;
  logic [31:0] in_address;
  logic        in_page_available;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_object_address;
  logic        out_page_obtained;
  logic        out_page_released;
  logic [31:0] out_page_address;
  logic [6:0]  out_total_pages;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          alloc_ok_count;
  int          release_count;
  int          nopage_count;
  int          cycle_count;
  int          idle_pct;

  // Addresses handed out and not yet freed, used to build well-formed frees
  logic [31:0] live_objects[$];

  slab_object_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_size(in_size), .in_address(in_address),
    .in_page_available(in_page_available), .out_valid(out_valid),
    .out_status(out_status), .out_object_address(out_object_address),
    .out_page_obtained(out_page_obtained), .out_page_released(out_page_released),
    .out_page_address(out_page_address), .out_total_pages(out_total_pages)
  );

  slab_alloc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_size(in_size), .in_address(in_address),
    .in_page_available(in_page_available), .out_valid(out_valid),
    .out_status(out_status), .out_object_address(out_object_address),
    .out_page_obtained(out_page_obtained), .out_page_released(out_page_released),
    .out_page_address(out_page_address), .out_total_pages(out_total_pages),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .alloc_ok_count(alloc_ok_count),
    .release_count(release_count), .nopage_count(nopage_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Collect granted objects so that later frees hit real objects
  always @(posedge clk) begin
    if (rst_n && out_valid && out_status == ST_OK && out_object_address != 0)
      live_objects.push_back(out_object_address);
  end

  // Run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Present one request, hold it until accepted and until busy drops again;
  // start stays high on return so a back-to-back request needs no extra edge
  task automatic send_request(logic op, logic [11:0] sz, logic [31:0] addr, logic avail);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_size <= sz;
    in_address <= addr;
    in_page_available <= avail;
    do @(posedge clk); while (busy);
  endtask

  // Free an object taken earlier, with some chance a recent one; allocate if none
  task automatic free_live_object();
    int k;
    logic [31:0] a;
    if (live_objects.size() == 0) begin
      send_request(OP_ALLOC, 12'($urandom_range(512, 0)), $urandom, 1'b1);
    end else begin
      k = ($urandom_range(1, 0)) ? live_objects.size() - 1 :
          $urandom_range(live_objects.size() - 1, 0);
      a = live_objects[k];
      live_objects.delete(k);
      send_request(OP_FREE, 12'($urandom), a, 1'($urandom_range(1, 0)));
    end
  endtask

  task automatic random_request();
    int pick;
    logic [31:0] a;
    pick = $urandom_range(99, 0);
    if (pick < 42) begin
      send_request(OP_ALLOC, 12'(16 << $urandom_range(5, 0)) - 12'($urandom_range(3, 0)),
                   $urandom, ($urandom_range(9, 0) != 0));
    end else if (pick < 80) begin
      free_live_object();
    end else if (pick < 86) begin
      // Free of a held object that stays in the list, so a later free repeats it
      a = (live_objects.size() > 0) ? live_objects[$urandom_range(live_objects.size() - 1, 0)]
                                    : BASE + 28;
      send_request(OP_FREE, 12'($urandom), a, 1'b1);
    end else if (pick < 92) begin
      // Any offset in pages 0 to 70: often misaligned, in the header or past the last page
      a = BASE + 4096 * $urandom_range(70, 0) + $urandom_range(4095, 0);
      send_request(OP_FREE, 12'($urandom), a, 1'b1);
    end else if (pick < 96) begin
      send_request(OP_ALLOC, 12'($urandom), $urandom, 1'($urandom_range(1, 0)));
    end else begin
      send_request(OP_FREE, 12'($urandom), $urandom, 1'($urandom_range(1, 0)));
    end
  endtask

  // Drop start and wait until every request sent so far is answered
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_operation <= OP_ALLOC;
    in_size <= '0;
    in_address <= '0;
    in_page_available <= 1'b0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, special cases
    send_request(OP_ALLOC, 12'd0, 32'h0, 1'b0);          // no page available
    send_request(OP_ALLOC, 12'd0, 32'hFFFFFFFF, 1'b1);   // size zero
    send_request(OP_ALLOC, 12'd16, 32'h0, 1'b1);
    send_request(OP_ALLOC, 12'd17, 32'h0, 1'b1);
    send_request(OP_ALLOC, 12'd512, 32'h0, 1'b1);
    send_request(OP_ALLOC, 12'd513, 32'h0, 1'b1);        // too large
    send_request(OP_ALLOC, 12'hFFF, 32'h0, 1'b1);
    send_request(OP_FREE, 12'hFFF, 32'h0, 1'b1);         // null
    send_request(OP_FREE, 12'd0, 32'hFFFFFFFF, 1'b0);    // outside region
    send_request(OP_FREE, 12'd0, BASE - 1, 1'b1);
    send_request(OP_FREE, 12'd0, BASE + 32'h00400000, 1'b1);
    send_request(OP_FREE, 12'd0, BASE + 4096 * 63 + 28, 1'b1); // dead page
    send_request(OP_FREE, 12'd0, BASE + 4, 1'b1);        // inside header
    send_request(OP_FREE, 12'd0, BASE + 29, 1'b1);       // between objects
    send_request(OP_FREE, 12'd0, BASE + 28 + 254 * 16, 1'b1); // past last object
    wait_drained();
    send_request(OP_FREE, 12'd0, BASE + 28 + 253 * 16, 1'b1);
    send_request(OP_FREE, 12'd0, BASE + 28 + 253 * 16, 1'b1); // double free
    // Fill the open 512-byte page and spill into a new one, then free held objects back
    repeat (7) send_request(OP_ALLOC, 12'd300, 32'h0, 1'b1);
    wait_drained();
    repeat (8) free_live_object();

    // Random phases with different sender idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 69 : (ph == 2) ? 13 : 0;
      repeat (125) random_request();
      if (ph == 1) begin
        // Hold off until every outstanding request is answered
        wait_drained();
        repeat (10) @(posedge clk);
      end
    end
    // Exhaust all page slots once with 512-byte objects
    idle_pct = 0;
    repeat (460) send_request(OP_ALLOC, 12'd512, 32'h0, 1'b1);
    repeat (60) free_live_object();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests: %0d good allocations, %0d page releases, %0d no-page refusals",
             result_count, alloc_ok_count, release_count, nopage_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
